### rtl/text_grid_buffer_with_scroll_assert.svh
// Assertion macros for the text grid buffer checker.
// Expects signals named clock and reset in the scope of use.
`ifndef TEXT_GRID_BUFFER_WITH_SCROLL_ASSERT_SVH
`define TEXT_GRID_BUFFER_WITH_SCROLL_ASSERT_SVH

// Next-cycle implication, masked while reset is high.
`define TGBS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tgbs assertion failed");

// Next-cycle implication that also holds across reset.
`define TGBS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tgbs assertion failed");

`endif

### rtl/tgbs_pkg.sv
// Shared types and constants for the text grid buffer with scroll.
// No dependencies.
package tgbs_pkg;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_SCROLL = 2'd3
   } tgbs_op_type;

   localparam logic [0:0] CSR_FILL_ADDR = 1'b0;

   // Request beat layout, lowest bit first.
   localparam int REQ_TDATA_W = 48;

   // Sweep start request.
   typedef struct packed {
      logic              valid;
      logic              scroll;
      logic signed [7:0] shift_rows;
      logic signed [7:0] shift_cols;
   } tgbs_start_type;

   // Per-cycle sweep status toward the grid memory.
   typedef struct packed {
      logic busy;
      logic valid;
      logic use_src;
   } tgbs_step_type;

endpackage

### rtl/tgbs_sweep.sv
// Address sequencer for clear, scroll and the post-reset clearing pass.
// Depends on tgbs_pkg.
module tgbs_sweep #(
   parameter int COLS = 64,
   parameter int ROWS = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  tgbs_pkg::tgbs_start_type                       start,
   output tgbs_pkg::tgbs_step_type                        step,
   output logic [((COLS*ROWS) > 1 ? $clog2(COLS*ROWS) : 1)-1:0] step_dest,
   output logic [((COLS*ROWS) > 1 ? $clog2(COLS*ROWS) : 1)-1:0] step_src
);

   localparam int Cells = COLS * ROWS;
   localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int XW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int YW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic signed [9:0] ColsS = 10'(COLS);
   localparam logic signed [9:0] RowsS = 10'(ROWS);

   typedef enum logic [1:0] {
      SW_IDLE = 2'b01,
      SW_RUN  = 2'b10
   } sw_state_type;

   sw_state_type       state_ff, state_in;
   logic [XW-1:0]      x_ff, x_in;
   logic [YW-1:0]      y_ff, y_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               down_ff, down_in;
   logic               scroll_ff, scroll_in;
   logic signed [7:0]  sr_ff, sr_in;
   logic signed [7:0]  sc_ff, sc_in;
   logic signed [17:0] d_ff, d_in;

   logic signed [9:0]  sx, sy;
   logic signed [17:0] src_s;
   logic signed [17:0] d_start;
   logic               in_range, last;

   // source cell coordinates and linear address
   assign sx       = $signed(10'(x_ff)) + 10'(sc_ff);
   assign sy       = $signed(10'(y_ff)) + 10'(sr_ff);
   assign in_range = scroll_ff && (sx >= 0) && (sx < ColsS) && (sy >= 0) && (sy < RowsS);
   assign src_s    = $signed(18'(addr_ff)) + d_ff;
   assign last     = down_ff ? (addr_ff == '0) : (addr_ff == AW'(Cells - 1));
   assign d_start  = 18'(start.shift_cols) + 18'(start.shift_rows) * 18'(COLS);

   assign step.busy    = (state_ff == SW_RUN);
   assign step.valid   = (state_ff == SW_RUN);
   assign step.use_src = in_range;
   assign step_dest    = addr_ff;
   assign step_src     = src_s[AW-1:0];

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      addr_in   = addr_ff;
      down_in   = down_ff;
      scroll_in = scroll_ff;
      sr_in     = sr_ff;
      sc_in     = sc_ff;
      d_in      = d_ff;
      unique case (state_ff)
         SW_IDLE: begin
            if (start.valid) begin
               state_in  = SW_RUN;
               scroll_in = start.scroll;
               sr_in     = start.shift_rows;
               sc_in     = start.shift_cols;
               d_in      = d_start;
               // source ahead of destination: walk upward, else downward
               down_in   = !(d_start > 0);
               if (d_start > 0) begin
                  x_in    = '0;
                  y_in    = '0;
                  addr_in = '0;
               end else begin
                  x_in    = XW'(COLS - 1);
                  y_in    = YW'(ROWS - 1);
                  addr_in = AW'(Cells - 1);
               end
            end
         end
         SW_RUN: begin
            if (last) begin
               state_in = SW_IDLE;
            end
            if (!down_ff) begin
               addr_in = addr_ff + AW'(1);
               if (x_ff == XW'(COLS - 1)) begin
                  x_in = '0;
                  y_in = y_ff + YW'(1);
               end else begin
                  x_in = x_ff + XW'(1);
               end
            end else begin
               addr_in = addr_ff - AW'(1);
               if (x_ff == '0) begin
                  x_in = XW'(COLS - 1);
                  y_in = y_ff - YW'(1);
               end else begin
                  x_in = x_ff - XW'(1);
               end
            end
         end
         default: state_in = SW_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // clearing pass after reset: upward fill sweep
         state_ff  <= SW_RUN;
         x_ff      <= '0;
         y_ff      <= '0;
         addr_ff   <= '0;
         down_ff   <= 1'b0;
         scroll_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         addr_ff   <= addr_in;
         down_ff   <= down_in;
         scroll_ff <= scroll_in;
      end
      sr_ff <= sr_in;
      sc_ff <= sc_in;
      d_ff  <= d_in;
   end

endmodule

### rtl/text_grid_buffer_with_scroll.sv
// Text grid buffer with scroll: top level with grid memory and result stage.
// Depends on tgbs_pkg and tgbs_sweep.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  req_     | in        | command beat: opcode, col, row, char, shifts
//  rsp_     | out       | result beat: char_out
//  csr_     | APB       | fill_char register at byte address 0
//
// Write and read commands are taken back to back while results flow; a result
// passes the s1 result slot and then waits in an output register.
// Clear and scroll walk every cell through the one read and one write port of
// the grid memory with req_tready low.
// After reset the same sweep clears the grid to zero.
// A stalled result beat holds one command in flight and stops intake.
module text_grid_buffer_with_scroll #(
   parameter int COLS = 64,
   parameter int ROWS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode[1:0], col[9:2], row[17:10], char_in[25:18],
                                    // shift_rows[33:26], shift_cols[41:34], zero pad
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_out[7:0]
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int Cells = COLS * ROWS;
   localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;

   // ---- request fields
   tgbs_pkg::tgbs_op_type opcode;
   logic [7:0]            col, row, char_in;
   logic signed [7:0]     shift_rows, shift_cols;
   logic [16:0]           cell_w;
   logic [AW-1:0]         cell_idx;
   logic                  in_range;

   assign opcode     = tgbs_pkg::tgbs_op_type'(req_tdata[1:0]);
   assign col        = req_tdata[9:2];
   assign row        = req_tdata[17:10];
   assign char_in    = req_tdata[25:18];
   assign shift_rows = $signed(req_tdata[33:26]);
   assign shift_cols = $signed(req_tdata[41:34]);

   assign in_range = (9'(col) < 9'(COLS)) && (9'(row) < 9'(ROWS));
   assign cell_w   = 17'(row) * 17'(COLS) + 17'(col);
   assign cell_idx = cell_w[AW-1:0];

   // ---- configuration register
   logic [7:0] fill_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == tgbs_pkg::CSR_FILL_ADDR) ? 32'(fill_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (csr_wr && (csr_paddr == tgbs_pkg::CSR_FILL_ADDR)) begin
         fill_ff <= csr_pwdata[7:0];
      end
   end

   // ---- handshake and result pipeline
   logic s1_valid_ff, s1_rd_ff;       // result slot; s1_rd_ff: take memory data
   logic rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic s1_move, accept, busy;
   logic wb_valid_ff, wb_src_ff;      // sweep write-back stage
   logic [AW-1:0] wb_addr_ff;
   logic [7:0] fill_lat_ff;           // fill char held for the running sweep
   logic [7:0] rd_ff;

   tgbs_pkg::tgbs_start_type start;
   tgbs_pkg::tgbs_step_type  step;
   logic [AW-1:0]            step_dest, step_src;

   assign busy       = step.busy || wb_valid_ff;
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy && (!s1_valid_ff || s1_move);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign start.valid      = accept &&
                             (opcode == tgbs_pkg::OP_CLEAR || opcode == tgbs_pkg::OP_SCROLL);
   assign start.scroll     = (opcode == tgbs_pkg::OP_SCROLL);
   assign start.shift_rows = shift_rows;
   assign start.shift_cols = shift_cols;

   tgbs_sweep #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_sweep (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .step      (step),
      .step_dest (step_dest),
      .step_src  (step_src)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wb_valid_ff  <= 1'b0;
         fill_lat_ff  <= '0;     // reset pass fills with zero
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         wb_valid_ff <= step.valid;
         if (start.valid) begin
            fill_lat_ff <= fill_ff;
         end
      end
      if (accept) begin
         s1_rd_ff <= (opcode == tgbs_pkg::OP_READ) && in_range;
      end
      if (s1_move) begin
         rsp_data_ff <= s1_rd_ff ? rd_ff : '0;
      end
      wb_addr_ff <= step_dest;
      wb_src_ff  <= step.use_src;
   end

   // ---- grid memory: one write port, one registered read port
   // Scroll reads the source in the cycle before writing the destination. The
   // sweep runs toward the source side, so a read never hits a cell already
   // rewritten in this pass, nor the cell being written in the same cycle.
   logic [7:0]    grid_mem [Cells];
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   always_comb begin
      priority if (wb_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wb_addr_ff;
         mem_wdata = wb_src_ff ? rd_ff : fill_lat_ff;
      end else begin
         mem_we    = accept && (opcode == tgbs_pkg::OP_WRITE) && in_range;
         mem_waddr = cell_idx;
         mem_wdata = char_in;
      end
   end

   assign mem_re    = step.valid || (accept && (opcode == tgbs_pkg::OP_READ));
   assign mem_raddr = step.valid ? step_src : cell_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= grid_mem[mem_raddr];
      end
   end

endmodule

### rtl/tgbs_checker.sv
// Port-level checker for the text grid buffer, bound to the top level.
// Depends on tgbs_pkg and text_grid_buffer_with_scroll_assert.svh.
`include "text_grid_buffer_with_scroll_assert.svh"

module tgbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   logic sweep_cmd;

   assign sweep_cmd = req_tvalid && req_tready &&
                      (req_tdata[1:0] == tgbs_pkg::OP_CLEAR ||
                       req_tdata[1:0] == tgbs_pkg::OP_SCROLL);

   // stalled result beat holds
   `TGBS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // clearing pass blocks intake right after reset
   `TGBS_ASSERT_NEXT_ALWAYS(a_reset_clear, reset, !req_tready)
   // clear and scroll stop intake while the grid is swept
   `TGBS_ASSERT_NEXT(a_sweep_stall, sweep_cmd, !req_tready)

endmodule

bind text_grid_buffer_with_scroll tgbs_checker u_tgbs_checker (.*);
